[design/amt_pkg.sv]
package amt_pkg;

  // field widths
  localparam int ROT_W    = 16;
  localparam int MOVE_W   = 24;
  localparam int CFG_W    = 24;
  localparam int IDX_W    = 2;
  localparam int OUT_W    = 32;
  localparam int IN_DATA_W  = 3 * ROT_W + 3 * MOVE_W;
  localparam int OUT_DATA_W = 2 * OUT_W;

  // serial units
  localparam int STEP_W = 6;
  localparam int MUL_W  = 26;
  localparam int PROD_W = 2 * MUL_W;
  localparam int RAD_W  = 64;
  localparam int ROOT_W = RAD_W / 2;
  localparam int REM_W  = ROOT_W + 2;
  localparam int SUM_W  = 64;
  localparam int CNT_W  = 32;

  // intermediate values
  localparam int VQ_W    = 32;            // sum of three Q1.15 squares
  localparam int TQ_W    = 48;            // sum of three Q16.16 squares
  localparam int S_W     = 17;            // |vector part|, Q1.16, capped at 1.0
  localparam int TRANS_W = 24;
  localparam int ROTE_W  = 25;            // 2 * range * s >> 16
  localparam int RANGE_SHIFT = 15;

  localparam logic [S_W-1:0] ONE_Q16 = S_W'(65536);

  localparam logic [STEP_W-1:0] ROT_SQ_STEPS  = STEP_W'(ROT_W);
  localparam logic [STEP_W-1:0] MOVE_SQ_STEPS = STEP_W'(MOVE_W);
  localparam logic [STEP_W-1:0] RANGE_STEPS   = STEP_W'(S_W);
  localparam logic [STEP_W-1:0] ERR_STEPS     = STEP_W'(MUL_W);
  localparam logic [STEP_W-1:0] VQ_ROOT_STEPS = STEP_W'((VQ_W + 2) / 2);
  localparam logic [STEP_W-1:0] TQ_ROOT_STEPS = STEP_W'(TQ_W / 2);
  localparam logic [STEP_W-1:0] SG_ROOT_STEPS = STEP_W'(ROOT_W);

  // register indexes
  localparam logic [IDX_W-1:0] REG_ADAPTIVE_ON  = 2'd0;
  localparam logic [IDX_W-1:0] REG_FIXED_LIMIT  = 2'd1;
  localparam logic [IDX_W-1:0] REG_MAP_SIGMA    = 2'd2;
  localparam logic [IDX_W-1:0] REG_SENSOR_RANGE = 2'd3;

  localparam logic [CFG_W-1:0] FIXED_LIMIT_RST  = CFG_W'(65536);
  localparam logic [CFG_W-1:0] SENSOR_RANGE_RST = CFG_W'(6553600);

  typedef struct packed {
    logic              go;
    logic [STEP_W-1:0] steps;
  } unit_cmd_t;

endpackage

[design/adaptive_match_threshold_core.sv]
// channel  dir  handshake           payload
// s_*      in   s_tvalid/s_tready   tdata: rot_x,rot_y,rot_z,move_x,move_y,move_z; tuser: func
// m_*      out  m_tvalid/m_tready   tdata: threshold, sample_total
// cfg_*    in   cfg_we              cfg_index, cfg_data (no read-back)
//
// One word at a time. Report-only words, and all words with adaptive_on = 0, go
// straight from accept to the result state. An update word runs six bit-serial
// squarings, three serial square roots, two serial products and the divide for
// the running mean. The new sigma is kept, so reports need no divide.
// Reset is synchronous, no sweep.
// A finished result waits in the output register; the next word is accepted
// meanwhile and only stalls at its own result if m_tready stays low.
module adaptive_match_threshold_core import amt_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,   // rot_x, rot_y, rot_z, move_x, move_y, move_z
  input  logic                  s_tuser,   // func
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,   // threshold, sample_total
  input  logic                  cfg_we,
  input  logic [IDX_W-1:0]      cfg_index,
  input  logic [CFG_W-1:0]      cfg_data
);

  localparam logic [3:0] ST_IDLE    = 4'd0;
  localparam logic [3:0] ST_SQ_GO   = 4'd1;
  localparam logic [3:0] ST_SQ_WAIT = 4'd2;
  localparam logic [3:0] ST_VR_GO   = 4'd3;
  localparam logic [3:0] ST_VR_WAIT = 4'd4;
  localparam logic [3:0] ST_RM_GO   = 4'd5;
  localparam logic [3:0] ST_RM_WAIT = 4'd6;
  localparam logic [3:0] ST_TR_GO   = 4'd7;
  localparam logic [3:0] ST_TR_WAIT = 4'd8;
  localparam logic [3:0] ST_ER_GO   = 4'd9;
  localparam logic [3:0] ST_ER_WAIT = 4'd10;
  localparam logic [3:0] ST_DV_GO   = 4'd11;
  localparam logic [3:0] ST_DV_WAIT = 4'd12;
  localparam logic [3:0] ST_SG_GO   = 4'd13;
  localparam logic [3:0] ST_SG_WAIT = 4'd14;
  localparam logic [3:0] ST_FIN     = 4'd15;

  localparam logic [2:0] LAST_TERM = 3'd5;
  localparam logic [2:0] MOVE_BASE = 3'd3;

  // configuration
  logic             adaptive_on;
  logic [CFG_W-1:0] fixed_limit;
  logic [CFG_W-1:0] map_sigma;
  logic [CFG_W-1:0] sensor_range;

  // running state
  logic [SUM_W-1:0]  sum;
  logic [CNT_W-1:0]  count;
  logic [ROOT_W-1:0] sigma;

  // per-word work registers
  logic [3:0]         state;
  logic [2:0]         term;
  logic [ROT_W-1:0]   rot_mag [3];
  logic [MOVE_W-1:0]  move_mag [3];
  logic [VQ_W-1:0]    vq;
  logic [TQ_W-1:0]    tq;
  logic [S_W-1:0]     s_val;
  logic [ROTE_W-1:0]  rot_err;
  logic [TRANS_W-1:0] trans;

  logic              out_valid;
  logic [OUT_W-1:0]  out_thr;
  logic [OUT_W-1:0]  out_cnt;

  // unit hookup
  unit_cmd_t         mul_cmd;
  logic [MUL_W-1:0]  mul_a;
  logic [MUL_W-1:0]  mul_b;
  logic [PROD_W-1:0] mul_prod;
  logic              mul_busy;
  unit_cmd_t         sq_cmd;
  logic [RAD_W-1:0]  sq_rad;
  logic [ROOT_W-1:0] sq_root;
  logic              sq_busy;
  logic              div_go;
  logic [SUM_W-1:0]  div_quo;
  logic              div_busy;

  logic              in_take;
  logic              out_free;
  logic [1:0]        move_sel;
  logic [MUL_W-1:0]  err;
  logic [SUM_W:0]    sum_add;
  logic [OUT_W:0]    sig_sum;
  logic [OUT_W+2:0]  thr_full;
  logic [OUT_W-1:0]  thr_val;

  assign s_tready = (state == ST_IDLE);
  assign in_take  = s_tvalid && s_tready;
  assign out_free = !out_valid || m_tready;
  assign move_sel = 2'(term - MOVE_BASE);
  assign err      = MUL_W'(trans) + MUL_W'(rot_err);
  assign sum_add  = {1'b0, sum} + {{(SUM_W + 1 - PROD_W){1'b0}}, mul_prod};

  // threshold = 3 * (map_sigma + sigma), saturated; fixed_limit when adaptive_on is 0
  assign sig_sum  = {1'b0, OUT_W'(map_sigma)} + {1'b0, sigma};
  assign thr_full = {1'b0, sig_sum, 1'b0} + {2'b00, sig_sum};
  assign thr_val  = !adaptive_on ? OUT_W'(fixed_limit) :
                    (thr_full[OUT_W+2:OUT_W] != 3'd0) ? '1 : thr_full[OUT_W-1:0];

  always_comb begin
    mul_cmd = '0;
    mul_a   = '0;
    mul_b   = '0;
    case (state)
      ST_SQ_GO: begin
        mul_cmd.go = 1'b1;
        if (term < MOVE_BASE) begin
          mul_cmd.steps = ROT_SQ_STEPS;
          mul_a = MUL_W'(rot_mag[term[1:0]]);
          mul_b = {rot_mag[term[1:0]], {(MUL_W-ROT_W){1'b0}}};
        end else begin
          mul_cmd.steps = MOVE_SQ_STEPS;
          mul_a = MUL_W'(move_mag[move_sel]);
          mul_b = {move_mag[move_sel], {(MUL_W-MOVE_W){1'b0}}};
        end
      end
      ST_RM_GO: begin
        mul_cmd.go    = 1'b1;
        mul_cmd.steps = RANGE_STEPS;
        mul_a = MUL_W'(sensor_range);
        mul_b = {s_val, {(MUL_W-S_W){1'b0}}};
      end
      ST_ER_GO: begin
        mul_cmd.go    = 1'b1;
        mul_cmd.steps = ERR_STEPS;
        mul_a = err;
        mul_b = err;
      end
      default: begin
        mul_cmd = '0;
      end
    endcase
  end

  always_comb begin
    sq_cmd = '0;
    sq_rad = '0;
    case (state)
      ST_VR_GO: begin
        sq_cmd.go    = 1'b1;
        sq_cmd.steps = VQ_ROOT_STEPS;
        sq_rad = {vq, 2'b00, {(RAD_W-VQ_W-2){1'b0}}};   // radicand is 4 * vq
      end
      ST_TR_GO: begin
        sq_cmd.go    = 1'b1;
        sq_cmd.steps = TQ_ROOT_STEPS;
        sq_rad = {tq, {(RAD_W-TQ_W){1'b0}}};
      end
      ST_SG_GO: begin
        sq_cmd.go    = 1'b1;
        sq_cmd.steps = SG_ROOT_STEPS;
        sq_rad = div_quo;
      end
      default: begin
        sq_cmd = '0;
      end
    endcase
  end

  assign div_go = (state == ST_DV_GO);

  amt_mul u_mul (
    .clk  (clk),
    .rst  (rst),
    .cmd  (mul_cmd),
    .a_in (mul_a),
    .b_in (mul_b),
    .prod (mul_prod),
    .busy (mul_busy)
  );

  amt_isqrt u_isqrt (
    .clk    (clk),
    .rst    (rst),
    .cmd    (sq_cmd),
    .rad_in (sq_rad),
    .root   (sq_root),
    .busy   (sq_busy)
  );

  amt_div u_div (
    .clk      (clk),
    .rst      (rst),
    .go       (div_go),
    .dividend (sum),
    .divisor  (count),
    .quotient (div_quo),
    .busy     (div_busy)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      adaptive_on  <= 1'b1;
      fixed_limit  <= FIXED_LIMIT_RST;
      map_sigma    <= '0;
      sensor_range <= SENSOR_RANGE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ADAPTIVE_ON:  adaptive_on  <= cfg_data[0];
        REG_FIXED_LIMIT:  fixed_limit  <= cfg_data;
        REG_MAP_SIGMA:    map_sigma    <= cfg_data;
        REG_SENSOR_RANGE: sensor_range <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // sequencer and running state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      term      <= '0;
      sum       <= '0;
      count     <= '0;
      sigma     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && m_tready && state != ST_FIN) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_take) begin
            term  <= '0;
            state <= (!s_tuser && adaptive_on) ? ST_SQ_GO : ST_FIN;
          end
        end
        ST_SQ_GO:   state <= ST_SQ_WAIT;
        ST_SQ_WAIT: begin
          if (!mul_busy) begin
            if (term == LAST_TERM) begin
              state <= ST_VR_GO;
            end else begin
              term  <= term + 1'b1;
              state <= ST_SQ_GO;
            end
          end
        end
        ST_VR_GO:   state <= ST_VR_WAIT;
        ST_VR_WAIT: if (!sq_busy) state <= ST_RM_GO;
        ST_RM_GO:   state <= ST_RM_WAIT;
        ST_RM_WAIT: if (!mul_busy) state <= ST_TR_GO;
        ST_TR_GO:   state <= ST_TR_WAIT;
        ST_TR_WAIT: if (!sq_busy) state <= ST_ER_GO;
        ST_ER_GO:   state <= ST_ER_WAIT;
        ST_ER_WAIT: begin
          if (!mul_busy) begin
            sum <= sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];
            if (count != '1) begin
              count <= count + 1'b1;
            end
            state <= ST_DV_GO;
          end
        end
        ST_DV_GO:   state <= ST_DV_WAIT;
        ST_DV_WAIT: if (!div_busy) state <= ST_SG_GO;
        ST_SG_GO:   state <= ST_SG_WAIT;
        ST_SG_WAIT: begin
          if (!sq_busy) begin
            sigma <= sq_root;
            state <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (out_free) begin
            out_valid <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // work datapath
  always_ff @(posedge clk) begin
    if (in_take) begin
      for (int i = 0; i < 3; i++) begin
        rot_mag[i]  <= s_tdata[i*ROT_W + ROT_W - 1] ?
                       ROT_W'(-s_tdata[i*ROT_W +: ROT_W]) : s_tdata[i*ROT_W +: ROT_W];
        move_mag[i] <= s_tdata[3*ROT_W + i*MOVE_W + MOVE_W - 1] ?
                       MOVE_W'(-s_tdata[3*ROT_W + i*MOVE_W +: MOVE_W]) :
                       s_tdata[3*ROT_W + i*MOVE_W +: MOVE_W];
      end
      vq <= '0;
      tq <= '0;
    end
    if (state == ST_SQ_WAIT && !mul_busy) begin
      if (term < MOVE_BASE) begin
        vq <= vq + mul_prod[VQ_W-1:0];
      end else begin
        tq <= tq + mul_prod[TQ_W-1:0];
      end
    end
    if (state == ST_VR_WAIT && !sq_busy) begin
      s_val <= (sq_root[S_W-1:0] > ONE_Q16) ? ONE_Q16 : sq_root[S_W-1:0];
    end
    if (state == ST_RM_WAIT && !mul_busy) begin
      rot_err <= mul_prod[RANGE_SHIFT +: ROTE_W];
    end
    if (state == ST_TR_WAIT && !sq_busy) begin
      trans <= sq_root[TRANS_W-1:0];
    end
    if (state == ST_FIN && out_free) begin
      out_thr <= thr_val;
      out_cnt <= count;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {out_cnt, out_thr};

  a_div_nonzero: assert property (@(posedge clk) disable iff (rst)
    state == ST_DV_GO |-> count != '0)
    else $error("divide started with zero sample count");

  a_sigma_zero: assert property (@(posedge clk) disable iff (rst)
    count == '0 |-> sigma == '0)
    else $error("nonzero sigma without samples");

  a_count_frozen: assert property (@(posedge clk) disable iff (rst)
    in_take && !adaptive_on |=> $stable(count))
    else $error("sample count moved with adaptive mode off");

  a_count_mono: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> count >= $past(count))
    else $error("sample count decreased");

endmodule

[design/amt_mul.sv]
// Bit-serial multiplier, multiplier operand MSB first, one bit per cycle.
// b_in must be left-aligned: only its top cmd.steps bits are consumed.
module amt_mul import amt_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  unit_cmd_t         cmd,
  input  logic [MUL_W-1:0]  a_in,
  input  logic [MUL_W-1:0]  b_in,
  output logic [PROD_W-1:0] prod,
  output logic              busy
);

  logic [PROD_W-1:0] acc;
  logic [MUL_W-1:0]  mcand;
  logic [MUL_W-1:0]  mplier;
  logic [STEP_W-1:0] cnt;
  logic [PROD_W-1:0] addend;

  assign addend = mplier[MUL_W-1] ? {{(PROD_W-MUL_W){1'b0}}, mcand} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (cmd.go) begin
      busy <= 1'b1;
      cnt  <= cmd.steps;
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == STEP_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.go) begin
      acc    <= '0;
      mcand  <= a_in;
      mplier <= b_in;
    end else if (busy) begin
      acc    <= {acc[PROD_W-2:0], 1'b0} + addend;
      mplier <= {mplier[MUL_W-2:0], 1'b0};
    end
  end

  assign prod = acc;

endmodule

[design/amt_isqrt.sv]
// Digit-by-digit square root: two radicand bits in, one root bit out per cycle.
// rad_in must be left-aligned so that cmd.steps digit pairs cover it.
module amt_isqrt import amt_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  unit_cmd_t         cmd,
  input  logic [RAD_W-1:0]  rad_in,
  output logic [ROOT_W-1:0] root,
  output logic              busy
);

  logic [RAD_W-1:0]  rad;
  logic [REM_W-1:0]  rem;
  logic [STEP_W-1:0] cnt;
  logic [REM_W+1:0]  rem_sh;
  logic [REM_W+1:0]  trial;
  logic [REM_W+1:0]  diff;
  logic              ge;

  assign rem_sh = {rem, rad[RAD_W-1 -: 2]};
  assign trial  = {{(REM_W-ROOT_W){1'b0}}, root, 2'b01};
  assign diff   = rem_sh - trial;
  assign ge     = (rem_sh >= trial);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (cmd.go) begin
      busy <= 1'b1;
      cnt  <= cmd.steps;
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == STEP_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.go) begin
      rad  <= rad_in;
      rem  <= '0;
      root <= '0;
    end else if (busy) begin
      rad  <= {rad[RAD_W-3:0], 2'b00};
      rem  <= ge ? diff[REM_W-1:0] : rem_sh[REM_W-1:0];
      root <= {root[ROOT_W-2:0], ge};
    end
  end

endmodule

[design/amt_div.sv]
// Restoring divider, one quotient bit per cycle.
module amt_div import amt_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             go,
  input  logic [SUM_W-1:0] dividend,
  input  logic [CNT_W-1:0] divisor,
  output logic [SUM_W-1:0] quotient,
  output logic             busy
);

  localparam int DCNT_W = $clog2(SUM_W);
  localparam logic [DCNT_W-1:0] LAST_STEP = DCNT_W'(SUM_W - 1);

  logic [CNT_W-1:0]  dvs;
  logic [CNT_W-1:0]  rem;
  logic [DCNT_W-1:0] cnt;
  logic [CNT_W:0]    rem_sh;
  logic [CNT_W:0]    diff;
  logic              ge;

  assign rem_sh = {rem, quotient[SUM_W-1]};
  assign diff   = rem_sh - {1'b0, dvs};
  assign ge     = (rem_sh >= {1'b0, dvs});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (go) begin
      busy <= 1'b1;
      cnt  <= LAST_STEP;
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == '0) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      quotient <= dividend;
      dvs      <= divisor;
      rem      <= '0;
    end else if (busy) begin
      rem      <= ge ? diff[CNT_W-1:0] : rem_sh[CNT_W-1:0];
      quotient <= {quotient[SUM_W-2:0], ge};
    end
  end

endmodule

[dv/testbench.sv]
`timescale 1ns / 1ps

module testbench;
  import amt_pkg::*;

  localparam int LIMIT_CYCLES = 1_000_000;
  localparam int RANDOM_WORDS = 160;   // per idling setting
  localparam int RECONFIG_EVERY = 40;

  typedef enum logic { FN_UPDATE = 1'b0, FN_REPORT = 1'b1 } func_e;

  typedef struct packed {
    logic [OUT_W-1:0] sample_total;
    logic [OUT_W-1:0] threshold;
  } report_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic                  s_tuser = 1'b0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  cfg_we = 1'b0;
  logic [IDX_W-1:0]      cfg_index = '0;
  logic [CFG_W-1:0]      cfg_data = '0;

  adaptive_match_threshold_core u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // tracker state and register copies
  logic              adaptive_en;
  logic [CFG_W-1:0]  fixed_thr;
  logic [CFG_W-1:0]  map_sig;
  logic [CFG_W-1:0]  range_q16;
  logic [63:0]       err_sq_sum;
  logic [31:0]       update_count;

  report_t     expected_reports[$];
  int unsigned errors = 0;
  int unsigned cycles = 0;
  int unsigned src_idle_pct = 0;
  int unsigned sink_idle_pct = 0;

  function automatic logic [63:0] floor_sqrt(input logic [63:0] v);
    logic [63:0] root, rem, probe;
    root = '0;
    rem = v;
    probe = 64'h4000_0000_0000_0000;
    while (probe > rem) probe = probe >> 2;
    while (probe != 0) begin
      if (rem >= root + probe) begin
        rem = rem - (root + probe);
        root = (root >> 1) + probe;
      end else begin
        root = root >> 1;
      end
      probe = probe >> 2;
    end
    return root;
  endfunction

  function automatic logic [63:0] sq_mag(input longint signed a);
    logic [63:0] m;
    m = (a < 0) ? 64'(-a) : 64'(a);
    return m * m;
  endfunction

  function automatic logic [31:0] current_threshold();
    logic [63:0] sigma, t;
    if (!adaptive_en) return 32'(fixed_thr);
    sigma = (update_count != 0) ? floor_sqrt(err_sq_sum / update_count) : 64'd0;
    t = 64'd3 * (64'(map_sig) + sigma);
    return (t > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : t[31:0];
  endfunction

  // advance the running error sum for one accepted word, queue its report
  function automatic void track_word(input func_e fn,
                                     input logic signed [ROT_W-1:0] rx, ry, rz,
                                     input logic signed [MOVE_W-1:0] mx, my, mz);
    logic [63:0] vq, tq, s, rot, trans, err, e2;
    report_t r;
    if (fn == FN_UPDATE && adaptive_en) begin
      vq = sq_mag(rx) + sq_mag(ry) + sq_mag(rz);
      tq = sq_mag(mx) + sq_mag(my) + sq_mag(mz);
      s = floor_sqrt(vq << 2);
      if (s > 64'd65536) s = 64'd65536;   // non-unit quaternion
      rot = (64'd2 * 64'(range_q16) * s) >> 16;
      trans = floor_sqrt(tq);
      err = trans + rot;
      e2 = err * err;
      if (err_sq_sum > ~64'd0 - e2) err_sq_sum = ~64'd0;
      else err_sq_sum = err_sq_sum + e2;
      if (update_count != 32'hFFFF_FFFF) update_count = update_count + 1;
    end
    r.threshold = current_threshold();
    r.sample_total = update_count;
    expected_reports.push_back(r);
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("testbench: errors");
      $finish;
    end
  end

  always @(negedge clk)
    m_tready = ($urandom_range(99) >= sink_idle_pct);

  always @(posedge clk) begin
    report_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata;
      if (expected_reports.size() == 0) begin
        $display("%0t: unexpected result word %h", $time, m_tdata);
        errors++;
      end else begin
        want = expected_reports.pop_front();
        if (got.threshold !== want.threshold) begin
          $display("%0t: threshold expected %0d got %0d", $time,
                   want.threshold, got.threshold);
          errors++;
        end
        if (got.sample_total !== want.sample_total) begin
          $display("%0t: sample_total expected %0d got %0d", $time,
                   want.sample_total, got.sample_total);
          errors++;
        end
      end
    end
  end

  task automatic send_word(input func_e fn,
                           input logic signed [ROT_W-1:0] rx, ry, rz,
                           input logic signed [MOVE_W-1:0] mx, my, mz);
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid = 1'b0;
      @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tuser = fn;
    s_tdata = {mz, my, mx, rz, ry, rx};
    do @(posedge clk); while (!s_tready);
    track_word(fn, rx, ry, rz, mx, my, mz);
    @(negedge clk);
  endtask

  // sender holds off until every report is back
  task automatic drain();
    s_tvalid = 1'b0;
    wait (expected_reports.size() == 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = value;
    case (idx)
      REG_ADAPTIVE_ON:  adaptive_en = value[0];
      REG_FIXED_LIMIT:  fixed_thr = value;
      REG_MAP_SIGMA:    map_sig = value;
      REG_SENSOR_RANGE: range_q16 = value;
      default: ;
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  function automatic logic signed [ROT_W-1:0] pick_rot();
    int unsigned sel;
    sel = $urandom_range(9);
    if (sel < 5) return ROT_W'(int'($urandom_range(4000)) - 2000);
    else if (sel < 8) return ROT_W'($urandom);
    else if (sel == 8) return $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
    else return '0;
  endfunction

  function automatic logic signed [MOVE_W-1:0] pick_move();
    int unsigned sel;
    sel = $urandom_range(9);
    if (sel < 5) return MOVE_W'(int'($urandom_range(400000)) - 200000);
    else if (sel < 8) return MOVE_W'($urandom);
    else if (sel == 8) return $urandom_range(1) ? 24'sh7FFFFF : 24'sh800000;
    else return '0;
  endfunction

  function automatic logic [CFG_W-1:0] pick_cfg(input logic [CFG_W-1:0] top);
    case ($urandom_range(3))
      0: return '0;
      1: return top;
      default: return CFG_W'($urandom_range(top));
    endcase
  endfunction

  task automatic test_reset_defaults();
    send_word(FN_REPORT, 16'sd1234, -16'sd1, 16'sd0, 24'sd5, -24'sd7, 24'sd9);
    send_word(FN_UPDATE, '0, '0, '0, 24'sd65536, '0, '0);
    send_word(FN_REPORT, '0, '0, '0, '0, '0, '0);
  endtask

  task automatic test_field_extremes();
    send_word(FN_UPDATE, 16'sh8000, 16'sh8000, 16'sh8000,
              24'sh800000, 24'sh800000, 24'sh800000);
    send_word(FN_UPDATE, 16'sh7FFF, '0, '0, 24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF);
    send_word(FN_UPDATE, '0, '0, 16'sh7FFF, '0, '0, '0);
    send_word(FN_UPDATE, '0, '0, '0, '0, '0, '0);
    send_word(FN_UPDATE, 16'sd100, -16'sd200, 16'sd300, -24'sd1, 24'sd1, -24'sd1);
    send_word(FN_REPORT, 16'shFFFF, 16'shFFFF, 16'shFFFF,
              24'shFFFFFF, 24'shFFFFFF, 24'shFFFFFF);
  endtask

  task automatic test_register_extremes();
    drain();
    write_reg(REG_SENSOR_RANGE, '0);
    send_word(FN_UPDATE, 16'sh7FFF, 16'sh7FFF, '0, 24'sd300, '0, '0);
    drain();
    write_reg(REG_SENSOR_RANGE, 24'd8388608);
    send_word(FN_UPDATE, 16'sh8000, '0, '0, '0, '0, '0);
    drain();
    write_reg(REG_MAP_SIGMA, 24'hFFFFFF);
    send_word(FN_REPORT, '0, '0, '0, '0, '0, '0);
    drain();
    write_reg(REG_MAP_SIGMA, '0);
    write_reg(REG_ADAPTIVE_ON, CFG_W'(1'b0));
    write_reg(REG_FIXED_LIMIT, '0);
    // updates are dropped while the fixed threshold is in use
    send_word(FN_UPDATE, 16'sd5000, 16'sd5000, 16'sd5000, 24'sd70000, '0, '0);
    send_word(FN_REPORT, '0, '0, '0, '0, '0, '0);
    drain();
    write_reg(REG_FIXED_LIMIT, 24'hFFFFFF);
    send_word(FN_REPORT, '0, '0, '0, '0, '0, '0);
    send_word(FN_UPDATE, '0, '0, '0, 24'sh7FFFFF, '0, '0);
    drain();
    write_reg(REG_ADAPTIVE_ON, CFG_W'(1'b1));
    write_reg(REG_FIXED_LIMIT, FIXED_LIMIT_RST);
    write_reg(REG_SENSOR_RANGE, SENSOR_RANGE_RST);
    send_word(FN_REPORT, '0, '0, '0, '0, '0, '0);
  endtask

  task automatic test_random_traffic(input int unsigned src_pct, input int unsigned sink_pct);
    func_e fn;
    src_idle_pct = src_pct;
    sink_idle_pct = sink_pct;
    for (int i = 0; i < RANDOM_WORDS; i++) begin
      if (i % RECONFIG_EVERY == RECONFIG_EVERY / 2) begin
        drain();
        write_reg(REG_ADAPTIVE_ON, CFG_W'($urandom_range(4) != 0));
        write_reg(REG_FIXED_LIMIT, pick_cfg(24'hFFFFFF));
        write_reg(REG_MAP_SIGMA, pick_cfg(24'hFFFFFF));
        write_reg(REG_SENSOR_RANGE, pick_cfg(24'd8388608));
      end
      fn = ($urandom_range(9) < 7) ? FN_UPDATE : FN_REPORT;
      send_word(fn, pick_rot(), pick_rot(), pick_rot(),
                pick_move(), pick_move(), pick_move());
    end
  endtask

  initial begin
    adaptive_en = 1'b1;
    fixed_thr = FIXED_LIMIT_RST;
    map_sig = '0;
    range_q16 = SENSOR_RANGE_RST;
    err_sq_sum = '0;
    update_count = '0;
    src_idle_pct = 18;
    sink_idle_pct = 73;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_reset_defaults();
    test_field_extremes();
    test_register_extremes();
    test_random_traffic(18, 73);
    test_random_traffic(73, 18);
    test_random_traffic(0, 0);

    s_tvalid = 1'b0;
    wait (expected_reports.size() == 0);
    repeat (400) @(posedge clk);
    if (errors == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
